// ----- sv/smeter_pkg.sv -----
// Shared types and constants for the stereo peak / RMS meter.
`default_nettype none

package smeter_pkg;

	localparam int MAX_BLOCK_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int DATA_W  = 24;
	localparam int SUM_W   = 59;
	localparam int TIME_W  = 32;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int CCNT_W  = 2;
	localparam int REG_IDX_W = 1;

	// Root extraction: radicand padded to an even bit count
	localparam int RAD_W   = SUM_W + 1;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int RREM_W  = ROOT_W + 1;
	localparam int SUB_W   = RREM_W + 2;
	localparam int STEP_W  = 7;

	localparam logic [DATA_W-1:0]  LEVEL_MAX = DATA_W'(8388608);
	localparam logic [DATA_W-1:0]  HOLD_RESET = DATA_W'(96000);
	localparam logic [CCNT_W-1:0]  CCNT_RESET = CCNT_W'(2);
	localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_HOLD_SAMPLES  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_WAIT_OUT,
		ST_ROOT_START,
		ST_ROOT_WAIT,
		ST_FINISH
	} sm_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQRT
	} ds_phase_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ds_status_t;

endpackage

`default_nettype wire

// ----- sv/smeter_root.sv -----
// Iterative mean and floor square root unit built around one shared subtractor.
`default_nettype none

module smeter_root
	import smeter_pkg::*;
#(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [SUM_W-1:0]                      dividend,
	input  wire logic [$clog2(MAX_BLOCK+1)-1:0]        divisor,
	output ds_status_t                                 status,
	output logic [DATA_W-1:0]                          root
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(RAD_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

	ds_phase_t           phase_q, phase_d;
	logic [STEP_W-1:0]   step_q;
	logic [RAD_W-1:0]    num_q;
	logic [RREM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic                done_q;

	logic [SUB_W-1:0]    op_a, op_b;
	logic [SUB_W:0]      diff;
	logic                ge;
	logic                last_step;

	// One subtractor serves the long division and the root digits
	always_comb begin
		if (phase_q == DS_SQRT) begin
			op_a = {rem_q, num_q[RAD_W-1 -: 2]};
			op_b = SUB_W'({root_q, 2'b01});
		end else begin
			op_a = SUB_W'({rem_q[CNT_W-1:0], num_q[RAD_W-1]});
			op_b = SUB_W'(divisor);
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = ~diff[SUB_W];
	end

	always_comb begin
		phase_d   = phase_q;
		last_step = 1'b0;
		case (phase_q)
			DS_IDLE: begin
				if (start) begin
					phase_d = DS_DIV;
				end
			end
			DS_DIV: begin
				if (step_q == DIV_LAST) begin
					phase_d = DS_SQRT;
				end
			end
			DS_SQRT: begin
				if (step_q == SQRT_LAST) begin
					phase_d   = DS_IDLE;
					last_step = 1'b1;
				end
			end
			default: begin
				phase_d = DS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DS_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= last_step;
			if (phase_q != phase_d) begin
				step_q <= '0;
			end else if (phase_q != DS_IDLE) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			DS_IDLE: begin
				if (start) begin
					num_q  <= {1'b0, dividend};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			DS_DIV: begin
				num_q <= {num_q[RAD_W-2:0], ge};
				// clear the remainder before the first root digit
				if (step_q == DIV_LAST) begin
					rem_q <= '0;
				end else begin
					rem_q <= ge ? diff[RREM_W-1:0] : op_a[RREM_W-1:0];
				end
			end
			DS_SQRT: begin
				num_q  <= {num_q[RAD_W-3:0], 2'b00};
				rem_q  <= ge ? diff[RREM_W-1:0] : op_a[RREM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign status.busy = (phase_q != DS_IDLE);
	assign status.done = done_q;
	assign root = (root_q > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : root_q[DATA_W-1:0];

endmodule

`default_nettype wire

// ----- sv/stereo_peak_rms_meter.sv -----
// Top level of the stereo peak / RMS meter: accumulation, sequencer and peak hold.
//
// Input channel s_*: one beat per stereo sample pair; s_tlast marks the last
// pair of a metering block. Output channel m_*: one beat per closed block with
// block peak, held peak and RMS for both channels.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 hold_samples, 1 channel_count); write only while the block is idle.
// Pair handling: after a pair is accepted, each metered channel in turn uses the
// single squaring multiplier and the sum adder while s_tready is low.
// A block end adds a wait state, a finish state and, per metered channel, a
// pass through the shared divide/root unit (start, 60 division steps, 30 root
// steps, done), so after the last pair of a block s_tready stays low until the
// result is registered.
// The result beat is raised in the finish state, after the root unit reports
// done for the last metered channel.
// Reset clears all accumulators, the hold state and sample time, and loads
// hold_samples with 96000 and channel_count with 2.
// When the receiver stalls, the result waits in place while further pairs are
// still accepted; the next block end holds before closing until it is taken.
`default_nettype none

module stereo_peak_rms_meter
	import smeter_pkg::*;
#(
	parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// sample_left [23:0], sample_right [47:24]
	input  wire logic [2*DATA_W-1:0]    s_tdata,
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// peak_left, peak_right, hold_left, hold_right, rms_left, rms_right,
	// 24 bits each from bit 0 up
	output logic [6*DATA_W-1:0]         m_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [REG_IDX_W-1:0]   cfg_index,
	input  wire logic [DATA_W-1:0]      cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);

	sm_state_t          state_q, state_d;

	logic [DATA_W-1:0]  hold_samples_q;
	logic [CCNT_W-1:0]  channel_count_q;

	logic [DATA_W-1:0]  running_peak_q [2];
	logic [SUM_W-1:0]   square_sum_q [2];
	logic [CNT_W-1:0]   block_count_q;
	logic [DATA_W-1:0]  held_peak_q [2];
	logic [TIME_W-1:0]  hold_stamp_q [2];
	logic [TIME_W-1:0]  sample_time_q;
	logic [DATA_W-1:0]  last_peak_q [2];
	logic [DATA_W-1:0]  last_rms_q [2];

	logic [DATA_W-1:0]  mag_q [2];
	logic [PROD_W-1:0]  prod_q;
	logic               ch_q;
	logic               stereo_q;
	logic               end_q;
	logic               out_valid_q;

	logic [DATA_W-1:0]  mag [2];
	logic [SUM_W:0]     sum_next;
	logic [TIME_W-1:0]  elapsed;
	logic               accept;
	logic               root_start;
	ds_status_t         root_status;
	logic [DATA_W-1:0]  root;

	// Magnitude of the low SAMPLE_BITS of each sample; the most negative code
	// keeps 2^(SAMPLE_BITS-1)
	always_comb begin
		logic [SAMPLE_BITS-1:0] raw;
		logic [SAMPLE_BITS-1:0] neg;
		for (int c = 0; c < 2; c++) begin
			raw = s_tdata[c*DATA_W +: SAMPLE_BITS];
			neg = ~raw + 1'b1;
			mag[c] = DATA_W'(raw[SAMPLE_BITS-1] ? neg : raw);
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign sum_next = {1'b0, square_sum_q[ch_q]} + (SUM_W+1)'(prod_q);
	assign elapsed  = sample_time_q - hold_stamp_q[ch_q];

	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (block_count_q < CNT_MAX) begin
						state_d = ST_SQ;
					end else if (s_tlast) begin
						state_d = ST_WAIT_OUT;
					end
				end
			end
			ST_SQ: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (stereo_q && !ch_q) begin
					state_d = ST_SQ;
				end else if (end_q) begin
					state_d = ST_WAIT_OUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WAIT_OUT: begin
				if (!out_valid_q) begin
					state_d = ST_ROOT_START;
				end
			end
			ST_ROOT_START: begin
				if (!root_status.busy) begin
					root_start = 1'b1;
					state_d    = ST_ROOT_WAIT;
				end
			end
			ST_ROOT_WAIT: begin
				if (root_status.done) begin
					state_d = (stereo_q && !ch_q) ? ST_ROOT_START : ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			hold_samples_q  <= HOLD_RESET;
			channel_count_q <= CCNT_RESET;
			block_count_q   <= '0;
			sample_time_q   <= '0;
			out_valid_q     <= 1'b0;
			ch_q            <= 1'b0;
			stereo_q        <= 1'b0;
			end_q           <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				running_peak_q[c] <= '0;
				square_sum_q[c]   <= '0;
				held_peak_q[c]    <= '0;
				hold_stamp_q[c]   <= '0;
				last_peak_q[c]    <= '0;
				last_rms_q[c]     <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_SAMPLES:  hold_samples_q  <= cfg_wdata;
					REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata[CCNT_W-1:0];
					default: begin
					end
				endcase
			end

			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stereo_q <= channel_count_q[1];
						end_q    <= s_tlast;
						ch_q     <= 1'b0;
						if (mag[0] > running_peak_q[0]) begin
							running_peak_q[0] <= mag[0];
						end
						if (channel_count_q[1] && mag[1] > running_peak_q[1]) begin
							running_peak_q[1] <= mag[1];
						end
						// freeze the count once the block is over-long
						if (block_count_q < CNT_MAX) begin
							block_count_q <= block_count_q + 1'b1;
						end
					end
				end
				ST_ACC: begin
					square_sum_q[ch_q] <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
					ch_q <= ~ch_q;
				end
				ST_WAIT_OUT: begin
					ch_q <= 1'b0;
				end
				ST_ROOT_WAIT: begin
					if (root_status.done) begin
						last_peak_q[ch_q] <= running_peak_q[ch_q];
						last_rms_q[ch_q]  <= root;
						if (running_peak_q[ch_q] > held_peak_q[ch_q]) begin
							held_peak_q[ch_q]  <= running_peak_q[ch_q];
							hold_stamp_q[ch_q] <= sample_time_q;
						end else if (elapsed > TIME_W'(hold_samples_q)) begin
							held_peak_q[ch_q] <= running_peak_q[ch_q];
						end
						ch_q <= ~ch_q;
					end
				end
				ST_FINISH: begin
					out_valid_q   <= 1'b1;
					sample_time_q <= sample_time_q + TIME_W'(block_count_q);
					block_count_q <= '0;
					for (int c = 0; c < 2; c++) begin
						running_peak_q[c] <= '0;
						square_sum_q[c]   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Square one channel per pass through the shared multiplier
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q[0] <= mag[0];
			mag_q[1] <= mag[1];
		end
		if (state_q == ST_SQ) begin
			prod_q <= mag_q[ch_q] * mag_q[ch_q];
		end
	end

	smeter_root #(
		.MAX_BLOCK(MAX_BLOCK)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.dividend (square_sum_q[ch_q]),
		.divisor  (block_count_q),
		.status   (root_status),
		.root     (root)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {last_rms_q[1], last_rms_q[0], held_peak_q[1], held_peak_q[0],
		last_peak_q[1], last_peak_q[0]};

endmodule

`default_nettype wire
